/* hdl/midi_gate_and_control_decoder_defines.svh */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - assertion macros
// Shared property forms for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MIDI_GATE_AND_CONTROL_DECODER_DEFINES_SVH
`define MIDI_GATE_AND_CONTROL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MGCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MGCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mgcd_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - package
// Types, constants and lookup tables shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mgcd_pkg;

  localparam int GATE_COUNT  = 8;
  localparam int POOF_MIN_MS = 50;
  localparam int POOF_MAX_MS = 1000;
  localparam int REST_MIN_MS = 50;
  localparam int REST_MAX_MS = 2000;

  localparam logic [15:0] GATE_MASK_ALL = 16'((32'd1 << GATE_COUNT) - 32'd1);

  localparam int SLOT_BASE  = 20;
  localparam int SLOT_COUNT = 7;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  localparam logic [SLOT_W-1:0] SLOT_ARM_A  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_ARM_B  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_MODE   = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_POOF   = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_REST   = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_RATE   = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_REPEAT = SLOT_W'(6);

  localparam logic [7:0] SLOT_UNSET       = 8'hFF;
  localparam logic [7:0] ST_REALTIME      = 8'hF8;
  localparam logic [7:0] ST_SENSE         = 8'hFE;
  localparam logic [3:0] KIND_NOTE_ON     = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF    = 4'h8;
  localparam logic [3:0] KIND_CTRL        = 4'hB;
  localparam logic [6:0] CC_SOUND_OFF     = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF     = 7'd123;
  localparam logic [6:0] CC_SLOT_FIRST    = 7'(SLOT_BASE);
  localparam logic [6:0] CC_SLOT_END      = 7'(SLOT_BASE + SLOT_COUNT);
  localparam logic [6:0] POOF_DEFAULT     = 7'd19;
  localparam logic [6:0] REST_DEFAULT     = 7'd10;
  localparam logic [7:0] RATE_UNSET_LEVEL = 8'd128;
  localparam logic [7:0] REPEAT_THRESHOLD = 8'd64;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_MSG   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_CHANNEL    = 3'd0,
    CFG_NOTE_FIRST = 3'd1,
    CFG_VEL_GATE   = 3'd2,
    CFG_ARM_A      = 3'd3,
    CFG_ARM_B      = 3'd4,
    CFG_SENSE_TO   = 3'd5,
    CFG_KEEPALIVE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_BYTE,
    CMD_SENSE,
    CMD_GATE_SET,
    CMD_GATE_CLR,
    CMD_SLOT,
    CMD_DISARM
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [31:0]       stamp;
    logic [3:0]        gate_idx;
    logic [SLOT_W-1:0] slot_idx;
    logic [6:0]        value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [6:0]  note_first;
    logic [6:0]  velocity_gate;
    logic [6:0]  arm_a_code;
    logic [6:0]  arm_b_code;
    logic [15:0] sensing_timeout_ms;
    logic [15:0] keepalive_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    channel:            4'd0,
    note_first:         7'd60,
    velocity_gate:      7'd64,
    arm_a_code:         7'd0,
    arm_b_code:         7'd0,
    sensing_timeout_ms: 16'd300,
    keepalive_ms:       16'd1000
  };

  typedef struct packed {
    logic        link_ok;
    logic        armed_a;
    logic        armed_b;
    logic [7:0]  mode_level;
    logic [15:0] poof_time_ms;
    logic [15:0] rest_time_ms;
    logic [7:0]  rate_level;
    logic        repeat_on;
    logic [15:0] gate_mask;
  } snap_t;

  typedef logic [15:0] time_tab_t [128];

  // lo + v*(hi-lo)/127 for every controller value, truncated toward zero
  function automatic time_tab_t build_time_tab(int lo, int hi);
    time_tab_t tab;
    int        r;
    for (int i = 0; i < 128; i++) begin
      r      = lo + (i * (hi - lo)) / 127;
      tab[i] = r[15:0];
    end
    return tab;
  endfunction

  localparam time_tab_t POOF_TAB = build_time_tab(POOF_MIN_MS, POOF_MAX_MS);
  localparam time_tab_t REST_TAB = build_time_tab(REST_MIN_MS, REST_MAX_MS);

endpackage

/* hdl/midi_gate_and_control_decoder.sv */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - top level
// Input items go in through push/full, one snapshot per item comes out
// through empty/pop in the same order.
// Configuration registers are written over cfg_valid_i/cfg_ready_o with
// cfg_index_i selecting the register; write only while no item is in flight.
// An accepted item is classified into the command queue, executed from
// there by the execution stage and its snapshot lands in the result queue.
// One item per cycle is sustained while the result queue has room; the
// execution stage, which updates the gate and slot state and reads the time
// tables, sets that rate.
// The result queue is four deep; while the receiver does not pop, execution
// holds, the command queue fills and full rises after eight waiting items.
// Reset empties both queues, clears all gates, marks every controller slot
// unset, forgets link activity and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_gate_and_control_decoder_defines.svh"

module midi_gate_and_control_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] time_ms_i,
  input  logic [7:0]  status_i,
  input  logic [6:0]  data_one_i,
  input  logic [6:0]  data_two_i,
  output logic        empty,
  input  logic        pop,
  output logic        link_ok_o,
  output logic        armed_a_o,
  output logic        armed_b_o,
  output logic [7:0]  mode_level_o,
  output logic [15:0] poof_time_ms_o,
  output logic [15:0] rest_time_ms_o,
  output logic [7:0]  rate_level_o,
  output logic        repeat_on_o,
  output logic [15:0] gate_mask_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  mgcd_pkg::cfg_t                cfg_q;
  mgcd_pkg::cmd_t                front_cmd;
  mgcd_pkg::cmd_t                cq_head;
  mgcd_pkg::snap_t               snap;
  mgcd_pkg::snap_t               res_head;
  logic                          accept;
  logic                          front_push;
  logic                          cq_empty;
  logic                          cq_pop;
  logic                          snap_valid;
  logic [mgcd_pkg::RQ_PTR_W:0]   res_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mgcd_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mgcd_pkg::CFG_CHANNEL:    cfg_q.channel            <= cfg_data_i[3:0];
        mgcd_pkg::CFG_NOTE_FIRST: cfg_q.note_first         <= cfg_data_i[6:0];
        mgcd_pkg::CFG_VEL_GATE:   cfg_q.velocity_gate      <= cfg_data_i[6:0];
        mgcd_pkg::CFG_ARM_A:      cfg_q.arm_a_code         <= cfg_data_i[6:0];
        mgcd_pkg::CFG_ARM_B:      cfg_q.arm_b_code         <= cfg_data_i[6:0];
        mgcd_pkg::CFG_SENSE_TO:   cfg_q.sensing_timeout_ms <= cfg_data_i;
        mgcd_pkg::CFG_KEEPALIVE:  cfg_q.keepalive_ms       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  mgcd_front u_front (
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .time_ms_i  (time_ms_i),
    .status_i   (status_i),
    .data_one_i (data_one_i),
    .data_two_i (data_two_i),
    .cfg_i      (cfg_q),
    .cmd_push_o (front_push),
    .cmd_o      (front_cmd)
  );

  mgcd_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .data_o  (cq_head)
  );

  mgcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (!cq_empty),
    .cmd_i        (cq_head),
    .cmd_pop_o    (cq_pop),
    .res_count_i  (res_count),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  mgcd_result_queue u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_valid),
    .data_i  (snap),
    .count_o (res_count),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_head)
  );

  assign link_ok_o      = res_head.link_ok;
  assign armed_a_o      = res_head.armed_a;
  assign armed_b_o      = res_head.armed_b;
  assign mode_level_o   = res_head.mode_level;
  assign poof_time_ms_o = res_head.poof_time_ms;
  assign rest_time_ms_o = res_head.rest_time_ms;
  assign rate_level_o   = res_head.rate_level;
  assign repeat_on_o    = res_head.repeat_on;
  assign gate_mask_o    = res_head.gate_mask;

  `MGCD_ASSERT_IMPL(a_gate_in_window, clk_i, rst_ni, !empty, (gate_mask_o & ~mgcd_pkg::GATE_MASK_ALL) == 16'd0, "gate set outside the note window")
  `MGCD_ASSERT_IMPL(a_armed_needs_link, clk_i, rst_ni, !empty && (armed_a_o || armed_b_o), link_ok_o, "side armed without a live link")
  `MGCD_ASSERT_IMPL(a_idle_latency, clk_i, rst_ni, accept && cq_empty && !snap_valid && empty, ##3 !empty, "result missing two cycles after an idle transfer")
  `MGCD_ASSERT_NEXT(a_no_overflow, clk_i, rst_ni, snap_valid, res_count <= (mgcd_pkg::RQ_PTR_W+1)'(mgcd_pkg::RQ_DEPTH), "result queue overrun")

endmodule

/* hdl/mgcd_front.sv */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - front end
// Classifies each accepted item into a command for the execution stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgcd_front (
  input  logic              accept_i,
  input  logic [1:0]        opcode_i,
  input  logic [31:0]       time_ms_i,
  input  logic [7:0]        status_i,
  input  logic [6:0]        data_one_i,
  input  logic [6:0]        data_two_i,
  input  mgcd_pkg::cfg_t    cfg_i,
  output logic              cmd_push_o,
  output mgcd_pkg::cmd_t    cmd_o
);

  logic [7:0] note_end;
  logic       in_window;
  logic [6:0] note_off;
  logic [6:0] slot_off;
  logic       is_on;
  logic       is_off;

  assign note_end  = {1'b0, cfg_i.note_first} + 8'(mgcd_pkg::GATE_COUNT);
  assign in_window = (data_one_i >= cfg_i.note_first) && ({1'b0, data_one_i} < note_end);
  assign note_off  = data_one_i - cfg_i.note_first;
  assign slot_off  = data_one_i - mgcd_pkg::CC_SLOT_FIRST;
  assign is_on     = (status_i[7:4] == mgcd_pkg::KIND_NOTE_ON);
  assign is_off    = (status_i[7:4] == mgcd_pkg::KIND_NOTE_OFF);

  assign cmd_push_o = accept_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = mgcd_pkg::CMD_NONE;
    cmd_o.stamp    = time_ms_i;
    cmd_o.gate_idx = note_off[3:0];
    cmd_o.slot_idx = slot_off[mgcd_pkg::SLOT_W-1:0];
    cmd_o.value    = data_two_i;
    case (opcode_i)
      mgcd_pkg::OP_BYTE: begin
        cmd_o.kind = mgcd_pkg::CMD_BYTE;
      end
      mgcd_pkg::OP_MSG: begin
        if (status_i >= mgcd_pkg::ST_REALTIME) begin
          // real-time: only active sensing counts
          if (status_i == mgcd_pkg::ST_SENSE) begin
            cmd_o.kind = mgcd_pkg::CMD_SENSE;
          end
        end else if (status_i[3:0] == cfg_i.channel) begin
          if ((is_on || is_off) && in_window) begin
            if (is_on && (data_two_i >= cfg_i.velocity_gate)) begin
              cmd_o.kind = mgcd_pkg::CMD_GATE_SET;
            end else if (is_off || (data_two_i == 7'd0)) begin
              cmd_o.kind = mgcd_pkg::CMD_GATE_CLR;
            end
          end else if (status_i[7:4] == mgcd_pkg::KIND_CTRL) begin
            if ((data_one_i >= mgcd_pkg::CC_SLOT_FIRST) &&
                (data_one_i < mgcd_pkg::CC_SLOT_END)) begin
              cmd_o.kind = mgcd_pkg::CMD_SLOT;
            end else if ((data_one_i == mgcd_pkg::CC_SOUND_OFF) ||
                         (data_one_i == mgcd_pkg::CC_NOTES_OFF)) begin
              cmd_o.kind = mgcd_pkg::CMD_DISARM;
            end
          end
        end
      end
      default: begin
        cmd_o.kind = mgcd_pkg::CMD_NONE;
      end
    endcase
  end

endmodule

/* hdl/mgcd_cmd_queue.sv */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - command queue
// Short queue between the front end and the execution stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgcd_cmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mgcd_pkg::cmd_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mgcd_pkg::cmd_t  data_o
);

  mgcd_pkg::cmd_t                  mem_q [mgcd_pkg::CQ_DEPTH];
  logic [mgcd_pkg::CQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mgcd_pkg::CQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mgcd_pkg::CQ_PTR_W:0]     count_q, count_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = (count_q == (mgcd_pkg::CQ_PTR_W+1)'(mgcd_pkg::CQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/mgcd_back.sv */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - execution stage
// Applies commands to the gate, slot and link state and builds the snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgcd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mgcd_pkg::cfg_t              cfg_i,
  input  logic                        cmd_valid_i,
  input  mgcd_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  input  logic [mgcd_pkg::RQ_PTR_W:0] res_count_i,
  output logic                        snap_valid_o,
  output mgcd_pkg::snap_t             snap_o
);

  logic [15:0] gate_q, gate_d;
  logic [7:0]  slots_q [mgcd_pkg::SLOT_COUNT];
  logic        sense_seen_q;
  logic [31:0] last_sense_q;
  logic        byte_seen_q;
  logic [31:0] last_byte_q;
  logic [31:0] stamp_q;
  logic        pend_q;

  logic [mgcd_pkg::RQ_PTR_W+1:0] in_flight;
  logic [15:0] gate_bit;
  logic [31:0] elapsed_sense;
  logic [31:0] elapsed_byte;
  logic        link;
  logic [6:0]  poof_v;
  logic [6:0]  rest_v;
  logic [7:0]  s_mode;
  logic [7:0]  s_rate;
  logic [7:0]  s_rep;

  // hold the queue while the result queue has no room for this snapshot
  assign in_flight = {1'b0, res_count_i} + (mgcd_pkg::RQ_PTR_W+2)'(pend_q);
  assign cmd_pop_o = cmd_valid_i &&
                     (in_flight < (mgcd_pkg::RQ_PTR_W+2)'(mgcd_pkg::RQ_DEPTH));
  assign gate_bit  = 16'd1 << cmd_i.gate_idx;

  always_comb begin
    gate_d = gate_q;
    case (cmd_i.kind)
      mgcd_pkg::CMD_GATE_SET: gate_d = gate_q | gate_bit;
      mgcd_pkg::CMD_GATE_CLR: gate_d = gate_q & ~gate_bit;
      mgcd_pkg::CMD_DISARM:   gate_d = '0;
      default:                gate_d = gate_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q       <= '0;
      sense_seen_q <= 1'b0;
      last_sense_q <= '0;
      byte_seen_q  <= 1'b0;
      last_byte_q  <= '0;
      pend_q       <= 1'b0;
      for (int i = 0; i < mgcd_pkg::SLOT_COUNT; i++) begin
        slots_q[i] <= mgcd_pkg::SLOT_UNSET;
      end
    end else begin
      pend_q <= cmd_pop_o;
      if (cmd_pop_o) begin
        gate_q <= gate_d;
        case (cmd_i.kind)
          mgcd_pkg::CMD_BYTE: begin
            byte_seen_q <= 1'b1;
            last_byte_q <= cmd_i.stamp;
          end
          mgcd_pkg::CMD_SENSE: begin
            sense_seen_q <= 1'b1;
            last_sense_q <= cmd_i.stamp;
          end
          mgcd_pkg::CMD_SLOT: begin
            slots_q[cmd_i.slot_idx] <= {1'b0, cmd_i.value};
          end
          mgcd_pkg::CMD_DISARM: begin
            slots_q[mgcd_pkg::SLOT_ARM_A] <= mgcd_pkg::SLOT_UNSET;
            slots_q[mgcd_pkg::SLOT_ARM_B] <= mgcd_pkg::SLOT_UNSET;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      stamp_q <= cmd_i.stamp;
    end
  end

  // snapshot of the state left by the command taken last cycle
  assign elapsed_sense = stamp_q - last_sense_q;
  assign elapsed_byte  = stamp_q - last_byte_q;
  assign link = sense_seen_q ? (elapsed_sense <= {16'd0, cfg_i.sensing_timeout_ms})
                             : (byte_seen_q && (elapsed_byte <= {16'd0, cfg_i.keepalive_ms}));

  assign s_mode = slots_q[mgcd_pkg::SLOT_MODE];
  assign s_rate = slots_q[mgcd_pkg::SLOT_RATE];
  assign s_rep  = slots_q[mgcd_pkg::SLOT_REPEAT];
  assign poof_v = (slots_q[mgcd_pkg::SLOT_POOF] == mgcd_pkg::SLOT_UNSET)
                  ? mgcd_pkg::POOF_DEFAULT : slots_q[mgcd_pkg::SLOT_POOF][6:0];
  assign rest_v = (slots_q[mgcd_pkg::SLOT_REST] == mgcd_pkg::SLOT_UNSET)
                  ? mgcd_pkg::REST_DEFAULT : slots_q[mgcd_pkg::SLOT_REST][6:0];

  always_comb begin
    snap_o.link_ok      = link;
    snap_o.armed_a      = link && (slots_q[mgcd_pkg::SLOT_ARM_A] == {1'b0, cfg_i.arm_a_code});
    snap_o.armed_b      = link && (slots_q[mgcd_pkg::SLOT_ARM_B] == {1'b0, cfg_i.arm_b_code});
    snap_o.mode_level   = (s_mode == mgcd_pkg::SLOT_UNSET) ? 8'd0 : {s_mode[6:0], 1'b0};
    snap_o.poof_time_ms = mgcd_pkg::POOF_TAB[poof_v];
    snap_o.rest_time_ms = mgcd_pkg::REST_TAB[rest_v];
    snap_o.rate_level   = (s_rate == mgcd_pkg::SLOT_UNSET) ? mgcd_pkg::RATE_UNSET_LEVEL
                                                           : {s_rate[6:0], 1'b0};
    snap_o.repeat_on    = (s_rep != mgcd_pkg::SLOT_UNSET) &&
                          (s_rep >= mgcd_pkg::REPEAT_THRESHOLD);
    snap_o.gate_mask    = gate_q;
  end

  assign snap_valid_o = pend_q;

endmodule

/* hdl/mgcd_result_queue.sv */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - result queue
// Holds finished snapshots until the receiver pops them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgcd_result_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mgcd_pkg::snap_t             data_i,
  output logic [mgcd_pkg::RQ_PTR_W:0] count_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output mgcd_pkg::snap_t             data_o
);

  mgcd_pkg::snap_t                 mem_q [mgcd_pkg::RQ_DEPTH];
  logic [mgcd_pkg::RQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mgcd_pkg::RQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mgcd_pkg::RQ_PTR_W:0]     count_q, count_d;
  logic                            do_pop;

  // the execution stage only pushes when a slot is free
  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* verif/midi_gate_and_control_decoder_tb.sv */
// ----------------------------------------------------------------------------
// MIDI gate and control decoder - testbench
// Drives timestamped byte notices, channel messages and queries through the
// push/full side and checks every snapshot popped from the empty/pop side
// against a cycle-free model of the gates, controller slots and link timers.
// A short directed table covers the extremes and the ignored cases; random
// phases follow, each under a fresh register setting, with random idling on
// both sides except in one steady phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_gate_and_control_decoder_tb;
  import mgcd_pkg::*;

  localparam logic [1:0] OP_SPARE      = 2'd3;   // unused opcode, acts as a query
  localparam logic [7:0] ST_STRAY      = 8'h70;  // data byte in status position
  localparam logic [7:0] ST_SYS_COMMON = 8'hF0;
  localparam int         PHASES        = 7;
  localparam int         PHASE_ITEMS   = 150;
  localparam int         DRAIN_TAIL    = 8;
  localparam int         STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
  } midi_item_t;

  typedef struct packed {
    midi_item_t item;
    logic       typed;
    snap_t      want;
  } dir_row_t;

  // nothing seen yet: default poof 19 -> 192 ms, default rest 10 -> 203 ms
  localparam snap_t SNAP_IDLE = '{1'b0, 1'b0, 1'b0, 8'd0, 16'd192, 16'd203, 8'd128,
                                  1'b0, 16'd0};
  localparam snap_t SNAP_LINK = '{1'b1, 1'b0, 1'b0, 8'd0, 16'd192, 16'd203, 8'd128,
                                  1'b0, 16'd0};
  localparam snap_t SNAP_NONE = '0;

  localparam dir_row_t DIRECTED [30] = '{
    '{'{OP_QUERY, 32'd0,    8'h00, 7'd0, 7'd0},   1'b1, SNAP_IDLE},
    '{'{OP_SPARE, 32'd5,    8'hFF, 7'h7F, 7'h7F}, 1'b1, SNAP_IDLE},
    '{'{OP_BYTE,  32'd100,  8'hFF, 7'h7F, 7'h7F}, 1'b1, SNAP_LINK},
    '{'{OP_QUERY, 32'd1100, 8'h00, 7'd0, 7'd0},   1'b0, SNAP_NONE},
    '{'{OP_QUERY, 32'd1101, 8'h00, 7'd0, 7'd0},   1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd1101, {KIND_CTRL, 4'd0}, CC_SLOT_FIRST, 7'd0},       1'b0, SNAP_NONE},
    '{'{OP_BYTE,  32'd2000, 8'h00, 7'd0, 7'd0},   1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_SLOT_FIRST + 7'd1, 7'd0},  1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_SLOT_FIRST + 7'd2, 7'd127}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_SLOT_FIRST + 7'd3, 7'd127}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_SLOT_FIRST + 7'd4, 7'd0},  1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_SLOT_FIRST + 7'd5, 7'd0},  1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_SLOT_FIRST + 7'd6, 7'd64}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_ON, 4'd0},  7'd60, 7'd64},  1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_ON, 4'd0},  7'd67, 7'd127}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_ON, 4'd0},  7'd61, 7'd63},  1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_ON, 4'd0},  7'd68, 7'd100}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_ON, 4'd1},  7'd62, 7'd100}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, ST_STRAY,              7'd62, 7'd100}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, ST_SYS_COMMON,         7'd62, 7'd100}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_ON, 4'd0},  7'd60, 7'd0},   1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_OFF, 4'd0}, 7'd67, 7'd0},   1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_NOTE_ON, 4'd0},  7'd62, 7'd100}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_SLOT_END, 7'd5}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'd2000, {KIND_CTRL, 4'd0}, CC_NOTES_OFF, 7'd0}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'hFFFF_FF00, ST_SENSE,    7'd0, 7'd0}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'h0000_002C, ST_REALTIME, 7'd0, 7'd0}, 1'b0, SNAP_NONE},
    '{'{OP_QUERY, 32'h0000_002D, 8'h00,       7'd0, 7'd0}, 1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'h0000_002D, {KIND_NOTE_ON, 4'd0}, 7'd63, 7'd100},        1'b0, SNAP_NONE},
    '{'{OP_MSG,   32'h0000_002D, {KIND_CTRL, 4'd0}, CC_SOUND_OFF, 7'd0},      1'b0, SNAP_NONE}
  };

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        pop         = 1'b0;
  logic [1:0]  opcode      = '0;
  logic [31:0] time_ms     = '0;
  logic [7:0]  status      = '0;
  logic [6:0]  data_one    = '0;
  logic [6:0]  data_two    = '0;
  logic        cfg_valid   = 1'b0;
  logic [2:0]  cfg_index   = '0;
  logic [15:0] cfg_data    = '0;
  logic        full, empty, cfg_ready;
  logic        link_ok, armed_a, armed_b, repeat_on;
  logic [7:0]  mode_level, rate_level;
  logic [15:0] poof_time_ms, rest_time_ms, gate_mask;

  // decoder state as the snapshots should see it
  cfg_t        cfg_mirror = CFG_RESET;
  logic [15:0] gates      = '0;
  logic [7:0]  slots [SLOT_COUNT];
  logic        sense_seen = 1'b0;
  logic [31:0] sense_ms   = '0;
  logic        byte_seen  = 1'b0;
  logic [31:0] byte_ms    = '0;

  snap_t       snap_q [$];
  logic [31:0] now_ms     = '0;
  bit          steady     = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          stall_cycles = 0;

  midi_gate_and_control_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode),
    .time_ms_i      (time_ms),
    .status_i       (status),
    .data_one_i     (data_one),
    .data_two_i     (data_two),
    .empty          (empty),
    .pop            (pop),
    .link_ok_o      (link_ok),
    .armed_a_o      (armed_a),
    .armed_b_o      (armed_b),
    .mode_level_o   (mode_level),
    .poof_time_ms_o (poof_time_ms),
    .rest_time_ms_o (rest_time_ms),
    .rate_level_o   (rate_level),
    .repeat_on_o    (repeat_on),
    .gate_mask_o    (gate_mask),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("%0t ns: result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  function automatic logic [15:0] scale_ms(input int v, input int lo, input int hi);
    int r;
    r = lo + (v * (hi - lo)) / 127;
    return r[15:0];
  endfunction

  // apply one item to the mirrored state and return the snapshot it yields
  function automatic snap_t decode_item(input midi_item_t it);
    snap_t      s;
    logic       link;
    logic [3:0] kind;
    int         off;
    kind = it.status[7:4];
    if (it.op == OP_BYTE) begin
      byte_seen = 1'b1;
      byte_ms   = it.now;
    end else if (it.op == OP_MSG) begin
      if (it.status >= ST_REALTIME) begin
        if (it.status == ST_SENSE) begin
          sense_seen = 1'b1;
          sense_ms   = it.now;
        end
      end else if (it.status[3:0] == cfg_mirror.channel) begin
        if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
          if (it.d1 >= cfg_mirror.note_first &&
              32'(it.d1) < 32'(cfg_mirror.note_first) + GATE_COUNT) begin
            off = int'(it.d1) - int'(cfg_mirror.note_first);
            if (kind == KIND_NOTE_ON && it.d2 >= cfg_mirror.velocity_gate) begin
              gates[off] = 1'b1;
            end else if (kind == KIND_NOTE_OFF || it.d2 == 7'd0) begin
              gates[off] = 1'b0;
            end
          end
        end else if (kind == KIND_CTRL) begin
          if (it.d1 >= CC_SLOT_FIRST && it.d1 < CC_SLOT_END) begin
            slots[int'(it.d1) - SLOT_BASE] = {1'b0, it.d2};
          end else if (it.d1 == CC_SOUND_OFF || it.d1 == CC_NOTES_OFF) begin
            gates = '0;
            slots[SLOT_ARM_A] = SLOT_UNSET;
            slots[SLOT_ARM_B] = SLOT_UNSET;
          end
        end
      end
    end
    // elapsed times wrap modulo 2^32
    if (sense_seen) link = (it.now - sense_ms) <= 32'(cfg_mirror.sensing_timeout_ms);
    else link = byte_seen && (it.now - byte_ms) <= 32'(cfg_mirror.keepalive_ms);
    s.link_ok      = link;
    s.armed_a      = link && slots[SLOT_ARM_A] == {1'b0, cfg_mirror.arm_a_code};
    s.armed_b      = link && slots[SLOT_ARM_B] == {1'b0, cfg_mirror.arm_b_code};
    s.mode_level   = (slots[SLOT_MODE] == SLOT_UNSET) ? 8'd0 : {slots[SLOT_MODE][6:0], 1'b0};
    s.poof_time_ms = scale_ms((slots[SLOT_POOF] == SLOT_UNSET) ? int'(POOF_DEFAULT)
                              : int'(slots[SLOT_POOF]), POOF_MIN_MS, POOF_MAX_MS);
    s.rest_time_ms = scale_ms((slots[SLOT_REST] == SLOT_UNSET) ? int'(REST_DEFAULT)
                              : int'(slots[SLOT_REST]), REST_MIN_MS, REST_MAX_MS);
    s.rate_level   = (slots[SLOT_RATE] == SLOT_UNSET) ? RATE_UNSET_LEVEL
                     : {slots[SLOT_RATE][6:0], 1'b0};
    s.repeat_on    = slots[SLOT_REPEAT] != SLOT_UNSET && slots[SLOT_REPEAT] >= REPEAT_THRESHOLD;
    s.gate_mask    = gates;
    return s;
  endfunction

  // mostly well-formed traffic on the configured channel, with some noise
  function automatic midi_item_t make_random_item();
    midi_item_t it;
    int         pick;
    int         n;
    logic [3:0] chan;
    pick = $urandom_range(99);
    if (pick < 3) now_ms = $urandom;
    else if (pick < 10) now_ms += $urandom_range(0, 3000);
    else now_ms += $urandom_range(0, 150);
    it.now    = now_ms;
    it.status = 8'($urandom);
    it.d1     = 7'($urandom);
    it.d2     = 7'($urandom);
    pick = $urandom_range(99);
    it.op = (pick < 12) ? OP_BYTE : (pick < 20) ? OP_QUERY : (pick < 23) ? OP_SPARE : OP_MSG;
    if (it.op == OP_MSG) begin
      chan = ($urandom_range(9) == 0) ? 4'($urandom) : cfg_mirror.channel;
      pick = $urandom_range(99);
      if (pick < 8) begin
        it.status = ST_SENSE;
      end else if (pick < 12) begin
        it.status = 8'($urandom_range(32'(ST_REALTIME), 255));
      end else if (pick < 20) begin
        // keep the random status
      end else if (pick < 55) begin
        it.status = {($urandom_range(2) == 0) ? KIND_NOTE_OFF : KIND_NOTE_ON, chan};
        n = int'(cfg_mirror.note_first) + $urandom_range(0, GATE_COUNT);
        if (n <= 127 && $urandom_range(9) != 0) it.d1 = 7'(n);
        pick = $urandom_range(3);
        if (pick == 0) it.d2 = 7'd0;
        else if (pick == 1) it.d2 = cfg_mirror.velocity_gate;
      end else begin
        it.status = {KIND_CTRL, chan};
        pick = $urandom_range(19);
        if (pick < 14) it.d1 = CC_SLOT_FIRST + 7'($urandom_range(0, SLOT_COUNT - 1));
        else if (pick < 16) it.d1 = $urandom_range(1) ? CC_SOUND_OFF : CC_NOTES_OFF;
        if ($urandom_range(1) == 1) begin
          if (it.d1 == CC_SLOT_FIRST) it.d2 = cfg_mirror.arm_a_code;
          else if (it.d1 == CC_SLOT_FIRST + 7'd1) it.d2 = cfg_mirror.arm_b_code;
        end
      end
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input midi_item_t it, input logic typed, input snap_t want);
    snap_t predicted;
    while (!steady && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push     <= 1'b1;
    opcode   <= it.op;
    time_ms  <= it.now;
    status   <= it.status;
    data_one <= it.d1;
    data_two <= it.d2;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predicted = decode_item(it);
    snap_q.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // hold the sender until every snapshot is back
  task automatic wait_drain();
    push <= 1'b0;
    while (snap_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_TAIL) @(negedge clk_i);
  endtask

  task automatic program_regs(input cfg_t c);
    cfg_idx_e    idx;
    logic [15:0] val;
    for (int i = 0; i <= int'(CFG_KEEPALIVE); i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_CHANNEL:    val = 16'(c.channel);
        CFG_NOTE_FIRST: val = 16'(c.note_first);
        CFG_VEL_GATE:   val = 16'(c.velocity_gate);
        CFG_ARM_A:      val = 16'(c.arm_a_code);
        CFG_ARM_B:      val = 16'(c.arm_b_code);
        CFG_SENSE_TO:   val = c.sensing_timeout_ms;
        default:        val = c.keepalive_ms;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid  <= 1'b0;
    cfg_mirror = c;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    pop <= steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin : check_results
    snap_t got;
    snap_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      got = '{link_ok, armed_a, armed_b, mode_level, poof_time_ms, rest_time_ms,
              rate_level, repeat_on, gate_mask};
      if (snap_q.size() == 0) begin
        report("snapshot popped with none outstanding");
      end else begin
        want = snap_q.pop_front();
        check_field("link_ok", 32'(got.link_ok), 32'(want.link_ok));
        check_field("armed_a", 32'(got.armed_a), 32'(want.armed_a));
        check_field("armed_b", 32'(got.armed_b), 32'(want.armed_b));
        check_field("mode_level", 32'(got.mode_level), 32'(want.mode_level));
        check_field("poof_time_ms", 32'(got.poof_time_ms), 32'(want.poof_time_ms));
        check_field("rest_time_ms", 32'(got.rest_time_ms), 32'(want.rest_time_ms));
        check_field("rate_level", 32'(got.rate_level), 32'(want.rate_level));
        check_field("repeat_on", 32'(got.repeat_on), 32'(want.repeat_on));
        check_field("gate_mask", 32'(got.gate_mask), 32'(want.gate_mask));
      end
    end
  end

  // count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t c;
    for (int i = 0; i < SLOT_COUNT; i++) slots[i] = SLOT_UNSET;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      case (p)
        0: c = '{4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 16'd0, 16'd0};
        1: c = '{4'hF, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 16'hFFFF, 16'hFFFF};
        default: begin
          c.channel            = 4'($urandom);
          c.note_first         = 7'($urandom);
          c.velocity_gate      = 7'($urandom_range(1, 127));
          c.arm_a_code         = 7'($urandom);
          c.arm_b_code         = 7'($urandom);
          c.sensing_timeout_ms = 16'($urandom_range(0, 600));
          c.keepalive_ms       = 16'($urandom_range(0, 1500));
        end
      endcase
      program_regs(c);
      // one phase runs across the 32-bit time wrap
      now_ms = (p == 3) ? 32'hFFFF_F000 : 32'($urandom);
      steady = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) wait_drain();
        send_item(make_random_item(), 1'b0, SNAP_NONE);
      end
    end
    steady = 1'b0;

    wait_drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/mgcd_pkg.sv
hdl/mgcd_front.sv
hdl/mgcd_cmd_queue.sv
hdl/mgcd_back.sv
hdl/mgcd_result_queue.sv
hdl/midi_gate_and_control_decoder.sv
verif/midi_gate_and_control_decoder_tb.sv
